### src/cdd_pkg.sv
// Package: shared widths, date type, calendar tables and leap-year logic.
package cdd_pkg;

    localparam int DAY_W        = 5;
    localparam int MONTH_W      = 4;
    localparam int YEAR_W       = 14;
    localparam int CNT_OUT_W    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(x * RECIP25 / 2^RECIP_SHIFT) equals floor(x / 25) for x below 4096
    localparam logic [11:0] RECIP25     = 12'd2622;
    localparam int          RECIP_SHIFT = 16;
    localparam logic [4:0]  DIV25       = 5'd25;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DONE
    } cdd_state_t;

    // Divisible by 100 is divisible by 4 with (y/4) % 25 == 0; same for 400 with y/16.
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [11:0] q4;
        logic [9:0]  q16;
        logic [23:0] p4;
        logic [21:0] p16;
        logic [11:0] r4;
        logic [9:0]  r16;
        q4  = y[YEAR_W-1:2];
        q16 = y[YEAR_W-1:4];
        p4  = 24'(q4) * 24'(RECIP25);
        p16 = 22'(q16) * 22'(RECIP25);
        r4  = q4 - 12'(p4[23:RECIP_SHIFT]) * 12'(DIV25);
        r16 = q16 - 10'(p16[21:RECIP_SHIFT]) * 10'(DIV25);
        return ((y[1:0] == 2'b00) && (r4 != 12'd0)) ||
               ((y[3:0] == 4'b0000) && (r16 == 10'd0));
    endfunction

    // Zero for a month outside 1..12, so no day passes the range check.
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        logic [3:0]       idx;
        len = '0;
        idx = m - 4'd1;
        if ((m >= MONTH_JAN) && (m <= MONTH_DEC))
        begin
            len = MONTH_LEN[idx];
            if ((m == MONTH_FEB) && leap)
            begin
                len = len + 5'd1;
            end
        end
        return len;
    endfunction

    function automatic logic date_ok(input date_t d);
        logic [DAY_W-1:0] len;
        len = days_in_month(d.month, leap_year(d.year));
        return (d.day != '0) && (d.day <= len);
    endfunction

endpackage

### src/cdd_if.sv
// Interfaces: input date-pair channel and result channel.
interface cdd_in_if;
    import cdd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

interface cdd_out_if;
    import cdd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CNT_OUT_W-1:0] day_count;
    logic                 count_overflow;
    logic                 date_invalid;

    modport source (
        output valid, day_count, count_overflow, date_invalid,
        input  ready
    );
    modport sink (
        input  valid, day_count, count_overflow, date_invalid,
        output ready
    );
endinterface

### src/cdd_step.sv
// Day-step unit: advances a calendar date by one day.
module cdd_step (
    input  cdd_pkg::date_t cur,
    output cdd_pkg::date_t next
);
    import cdd_pkg::*;

    logic [DAY_W-1:0] len;

    assign len = days_in_month(cur.month, leap_year(cur.year));

    always_comb
    begin
        next = cur;
        if (cur.day == len)
        begin
            next.day = 5'd1;
            if (cur.month == MONTH_DEC)
            begin
                next.month = MONTH_JAN;
                next.year  = cur.year + 14'd1;
            end
            else
            begin
                next.month = cur.month + 4'd1;
            end
        end
        else
        begin
            next.day = cur.day + 5'd1;
        end
    end

endmodule

### src/calendar_day_difference_core.sv
// Top level: validates two dates, then, if both are valid, walks the earlier one to the later one a day per cycle.
// Saturation: the walk stops at 2^COUNT_BITS - 1 steps and reports overflow. Invalid dates
//   skip the walk and go straight to the result.
// Throughput: one item at a time; the single day-step unit sets the pace, one day per cycle;
//   ready returns the cycle after the result transfer.
// Reset: rst_n asynchronous, active low; returns the sequencer to idle with no result pending.
module calendar_day_difference_core #(
    parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    cdd_in_if.sink           in_ch,
    cdd_out_if.source        out_ch
);
    import cdd_pkg::*;

    cdd_state_t              state_reg, state_next;
    date_t                   a_reg, b_reg;
    date_t                   cur_reg, tgt_reg;
    date_t                   cur_step;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [CNT_OUT_W-1:0]    day_count_reg;
    logic                    ovf_reg;
    logic                    inv_reg;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    dates_ok;
    logic                    a_first;
    logic                    walk_hit;
    logic                    walk_sat;
    logic [COUNT_BITS+CNT_OUT_W-1:0] count_ext;

    cdd_step u_step (
        .cur  (cur_reg),
        .next (cur_step)
    );

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign out_xfer  = out_ch.valid && out_ch.ready;
    assign dates_ok  = date_ok(a_reg) && date_ok(b_reg);
    assign a_first   = (a_reg <= b_reg);
    assign walk_hit  = (cur_reg == tgt_reg);
    assign walk_sat  = (count_reg == '1);
    assign count_ext = (COUNT_BITS+CNT_OUT_W)'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = dates_ok ? S_WALK : S_DONE;
            end
            S_WALK:
            begin
                if (walk_hit || walk_sat)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready  = (state_reg == S_IDLE);
        out_ch.valid = (state_reg == S_DONE);
        out_ch.day_count      = day_count_reg;
        out_ch.count_overflow = ovf_reg;
        out_ch.date_invalid   = inv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    a_reg <= '{year: in_ch.first_year, month: in_ch.first_month,
                               day: in_ch.first_day};
                    b_reg <= '{year: in_ch.second_year, month: in_ch.second_month,
                               day: in_ch.second_day};
                end
            end
            S_CHECK:
            begin
                // order the dates so the walk always moves forward
                cur_reg   <= a_first ? a_reg : b_reg;
                tgt_reg   <= a_first ? b_reg : a_reg;
                count_reg <= '0;
                if (!dates_ok)
                begin
                    day_count_reg <= '0;
                    ovf_reg       <= 1'b0;
                    inv_reg       <= 1'b1;
                end
            end
            S_WALK:
            begin
                if (walk_hit)
                begin
                    day_count_reg <= count_ext[CNT_OUT_W-1:0];
                    ovf_reg       <= 1'b0;
                    inv_reg       <= 1'b0;
                end
                else if (walk_sat)
                begin
                    day_count_reg <= count_ext[CNT_OUT_W-1:0];
                    ovf_reg       <= 1'b1;
                    inv_reg       <= 1'b0;
                end
                else
                begin
                    cur_reg   <= cur_step;
                    count_reg <= count_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // hold the result until the transfer
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_walk_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cur_reg <= tgt_reg))
        else $error("walking date passed the target date");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.date_invalid) |->
            ((out_ch.day_count == '0) && !out_ch.count_overflow))
        else $error("invalid result carries a nonzero count or overflow");

    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.count_overflow) |-> (count_reg == '1))
        else $error("overflow reported without a saturated count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && !walk_hit && !walk_sat) |=>
            (count_reg == COUNT_BITS'($past(count_reg) + 1'b1)))
        else $error("day counter did not advance by one");
`endif

endmodule

### verif/tb_top.sv
// Testbench for calendar_day_difference_core: date pairs in, checked day counts out.
module tb_top;
    import cdd_pkg::*;

    localparam longint WATCHDOG_TIME = 64'd200_000_000;
    localparam longint COUNT_LIMIT   = (longint'(1) << COUNT_BITS_DEF) - 1;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] day_count;
        logic                 count_overflow;
        logic                 date_invalid;
    } day_gap_t;

    logic clk;
    logic rst_n;

    cdd_in_if  date_ch();
    cdd_out_if gap_ch();

    calendar_day_difference_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (date_ch),
        .out_ch (gap_ch)
    );

    day_gap_t pending_gaps[$];
    int       fail_count     = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_TIME);
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        gap_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int month_length(input int m, input int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:       return 0;
        endcase
    endfunction

    function automatic bit real_date(input date_t d);
        return (d.day != 0) && (int'(d.day) <= month_length(int'(d.month), int'(d.year)));
    endfunction

    // Days since 1 Jan of year zero; only meaningful for a real date.
    function automatic longint epoch_day(input date_t d);
        longint y;
        longint n;
        int     m;
        y = d.year;
        n = 365 * y;
        if (y > 0)
        begin
            n += 1 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
        end
        for (m = 1; m < int'(d.month); m++)
        begin
            n += month_length(m, int'(y));
        end
        return n + d.day - 1;
    endfunction

    function automatic day_gap_t predict_gap(input date_t a, input date_t b);
        day_gap_t r;
        longint   diff;
        r = '0;
        if (!real_date(a) || !real_date(b))
        begin
            r.date_invalid = 1'b1;
            return r;
        end
        diff = epoch_day(a) - epoch_day(b);
        if (diff < 0)
        begin
            diff = -diff;
        end
        if (diff > COUNT_LIMIT)
        begin
            r.day_count      = CNT_OUT_W'(COUNT_LIMIT);
            r.count_overflow = 1'b1;
        end
        else
        begin
            r.day_count = CNT_OUT_W'(diff);
        end
        return r;
    endfunction

    function automatic date_t mk_date(input int d, input int m, input int y);
        date_t r;
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    // Step a real date forward one day at a time.
    function automatic date_t shift_date(input date_t d, input int unsigned n);
        date_t r;
        int unsigned i;
        r = d;
        for (i = 0; i < n; i++)
        begin
            if (int'(r.day) < month_length(int'(r.month), int'(r.year)))
            begin
                r.day = r.day + 1'b1;
            end
            else
            begin
                r.day = DAY_W'(1);
                if (r.month == MONTH_DEC)
                begin
                    r.month = MONTH_JAN;
                    r.year  = r.year + 1'b1;
                end
                else
                begin
                    r.month = r.month + 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic date_t rand_real_date(input int lo_year, input int hi_year);
        int y;
        int m;
        y = $urandom_range(hi_year, lo_year);
        m = $urandom_range(12, 1);
        return mk_date($urandom_range(month_length(m, y), 1), m, y);
    endfunction

    // Result checker: sample at the falling edge, the transfer lands on the next rising edge.
    always @(negedge clk)
    begin
        day_gap_t want;
        day_gap_t got;
        if (rst_n && gap_ch.valid && gap_ch.ready)
        begin
            got.day_count      = gap_ch.day_count;
            got.count_overflow = gap_ch.count_overflow;
            got.date_invalid   = gap_ch.date_invalid;
            if (pending_gaps.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("unexpected result: count=%0d ovf=%0b inv=%0b",
                             got.day_count, got.count_overflow, got.date_invalid);
                end
            end
            else
            begin
                want = pending_gaps.pop_front();
                if ((got.day_count !== want.day_count) ||
                    (got.count_overflow !== want.count_overflow) ||
                    (got.date_invalid !== want.date_invalid))
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected count=%0d ovf=%0b inv=%0b, got count=%0d ovf=%0b inv=%0b",
                                 want.day_count, want.count_overflow, want.date_invalid,
                                 got.day_count, got.count_overflow, got.date_invalid);
                    end
                end
            end
        end
    end

    // Called and returns at a rising edge; valid stays high after the transfer.
    task automatic send_pair(input date_t a, input date_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            date_ch.valid <= 1'b0;
            @(posedge clk);
        end
        date_ch.valid        <= 1'b1;
        date_ch.first_day    <= a.day;
        date_ch.first_month  <= a.month;
        date_ch.first_year   <= a.year;
        date_ch.second_day   <= b.day;
        date_ch.second_month <= b.month;
        date_ch.second_year  <= b.year;
        @(negedge clk);
        while (!date_ch.ready)
        begin
            @(negedge clk);
        end
        pending_gaps.push_back(predict_gap(a, b));
        @(posedge clk);
    endtask

    // Hold the sender until every result has come back.
    task automatic drain_results();
        date_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_gaps.size() != 0);
    endtask

    task automatic test_equal_and_adjacent();
        send_pair(mk_date(15, 6, 2024), mk_date(15, 6, 2024));
        send_pair(mk_date(31, 1, 2023), mk_date(1, 2, 2023));
        send_pair(mk_date(1, 1, 2000), mk_date(31, 12, 1999));
        send_pair(mk_date(28, 2, 2023), mk_date(1, 3, 2023));
    endtask

    task automatic test_leap_years();
        send_pair(mk_date(28, 2, 2024), mk_date(1, 3, 2024));
        send_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
        send_pair(mk_date(29, 2, 1900), mk_date(1, 3, 1900));
        send_pair(mk_date(1, 3, 2023), mk_date(29, 2, 2023));
        send_pair(mk_date(29, 2, 0), mk_date(1, 1, 0));
        send_pair(mk_date(29, 2, 16000), mk_date(31, 12, 16000));
    endtask

    task automatic test_invalid_dates();
        send_pair(mk_date(10, 0, 2010), mk_date(10, 5, 2010));
        send_pair(mk_date(10, 13, 2010), mk_date(10, 5, 2010));
        send_pair(mk_date(10, 5, 2010), mk_date(31, 15, 16383));
        send_pair(mk_date(0, 5, 2010), mk_date(10, 5, 2010));
        send_pair(mk_date(31, 4, 2010), mk_date(30, 4, 2010));
        send_pair(mk_date(30, 4, 2010), mk_date(31, 12, 2010));
        send_pair(mk_date(31, 12, 16383), mk_date(1, 12, 16383));
    endtask

    task automatic test_count_limit();
        date_t base;
        base = mk_date(1, 1, 2000);
        send_pair(base, shift_date(base, 32'(COUNT_LIMIT)));
        send_pair(shift_date(base, 32'(COUNT_LIMIT + 1)), base);
        send_pair(mk_date(1, 1, 0), mk_date(31, 12, 16383));
        drain_results();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n, input bit pause_midway);
        date_t a;
        date_t b;
        date_t t;
        int    k;
        int    y;
        int    i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 55)
            begin
                // Short walks, a third of them around century and leap corners.
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(7))
                        0: y = 0;
                        1: y = 4;
                        2: y = 100;
                        3: y = 400;
                        4: y = 1900;
                        5: y = 2000;
                        6: y = 2100;
                        default: y = 16000;
                    endcase
                    a = rand_real_date(y, y);
                end
                else
                begin
                    a = rand_real_date(0, 16380);
                end
                b = shift_date(a, $urandom_range(60));
            end
            else if (k < 70)
            begin
                a = rand_real_date(0, 16370);
                b = shift_date(a, $urandom_range(1000));
            end
            else if (k < 75)
            begin
                a = rand_real_date(0, 16383);
                b = rand_real_date(0, 16383);
            end
            else
            begin
                // Raw fields in a shared year: often broken dates, walks within the year otherwise.
                y = $urandom_range(16383);
                a = mk_date($urandom_range(31), $urandom_range(15), y);
                b = mk_date($urandom_range(31), $urandom_range(15), y);
            end
            if ($urandom_range(1) == 1)
            begin
                t = a;
                a = b;
                b = t;
            end
            send_pair(a, b);
            if (pause_midway && (i == n / 2))
            begin
                drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        date_ch.valid        = 1'b0;
        date_ch.first_day    = '0;
        date_ch.first_month  = '0;
        date_ch.first_year   = '0;
        date_ch.second_day   = '0;
        date_ch.second_month = '0;
        date_ch.second_year  = '0;
        gap_ch.ready         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_equal_and_adjacent();
        test_leap_years();
        test_invalid_dates();
        test_count_limit();
        test_random_phase(0, 0, 25, 1'b1);
        test_random_phase(77, 0, 25, 1'b0);
        test_random_phase(0, 77, 25, 1'b0);
        test_random_phase(37, 37, 25, 1'b1);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_gaps.size() == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
